// ----- rtl/callsign_repeat_holdoff_table_defines.svh -----
// ----------------------------------------------------------------------------
// Callsign holdoff table assertion macros
// Shared property shorthands for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef CALLSIGN_REPEAT_HOLDOFF_TABLE_DEFINES_SVH
`define CALLSIGN_REPEAT_HOLDOFF_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CRHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define CRHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/crht_pkg.sv -----
// ----------------------------------------------------------------------------
// Callsign holdoff table package
// Widths, reset values, register codes and the request and entry types.
// ----------------------------------------------------------------------------
package crht_pkg;

  localparam int ENTRY_COUNT_DEF = 32;
  localparam int KEY_W           = 72;
  localparam int STAMP_W         = 32;
  localparam int HOLDOFF_W       = 16;
  localparam int SLOT_W          = 5;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 16'd30;
  localparam logic [7:0]           KEY_CUT_CHAR  = 8'h3E;

  // Register index, taken from paddr[2].
  localparam logic REG_HOLDOFF = 1'b0;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    key_t               key;
    logic [STAMP_W-1:0] now;
  } req_t;

  typedef struct packed {
    key_t               key;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

// ----- rtl/crht_ifs.sv -----
// ----------------------------------------------------------------------------
// Callsign holdoff table channels
// Valid/ready channels for requests and for results.
// ----------------------------------------------------------------------------
interface crht_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_head;
  logic [7:0]  key_tail;
  logic [31:0] now_seconds;

  modport source (output valid, output key_head, output key_tail, output now_seconds,
                  input ready);
  modport sink (input valid, input key_head, input key_tail, input now_seconds,
                output ready);
endinterface

interface crht_out_if;
  logic       valid;
  logic       ready;
  logic       too_soon;
  logic       recorded;
  logic [4:0] slot_used;

  modport source (output valid, output too_soon, output recorded, output slot_used,
                  input ready);
  modport sink (input valid, input too_soon, input recorded, input slot_used,
                output ready);
endinterface

// ----- rtl/crht_cfg.sv -----
// ----------------------------------------------------------------------------
// Callsign holdoff table register port
// APB-style slave holding the holdoff window register.
// ----------------------------------------------------------------------------
module crht_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [crht_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [crht_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [crht_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready,
  output logic [crht_pkg::HOLDOFF_W-1:0]       holdoff
);

  logic [crht_pkg::HOLDOFF_W-1:0] holdoff_r;
  logic                           wr_hit;

  assign cfg_pready = 1'b1;
  assign wr_hit = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[2] == crht_pkg::REG_HOLDOFF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_r <= crht_pkg::HOLDOFF_RESET;
    end else if (wr_hit) begin
      holdoff_r <= cfg_pwdata[crht_pkg::HOLDOFF_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == crht_pkg::REG_HOLDOFF) begin
      cfg_prdata = crht_pkg::CFG_DATA_W'(holdoff_r);
    end
  end

  assign holdoff = holdoff_r;

endmodule

// ----- rtl/crht_front.sv -----
// ----------------------------------------------------------------------------
// Callsign holdoff table front end
// Accepts requests, normalizes the key and hands them to the queue.
// ----------------------------------------------------------------------------
module crht_front (
  input  logic           clk,
  input  logic           rst_n,
  crht_in_if.sink        in_if,
  output logic           push_valid,
  input  logic           push_ready,
  output crht_pkg::req_t push_data
);

  logic           f_valid_r;
  crht_pkg::req_t f_data_r;

  // The key is cut at the first NUL or '>' byte; that byte and all after it read as zero.
  function automatic crht_pkg::key_t normalize_key(input logic [63:0] head,
                                                   input logic [7:0]  tail);
    logic [8:0][7:0] b;
    logic            cut;
    b   = {head, tail};
    cut = 1'b0;
    for (int i = 8; i >= 0; i--) begin
      if (b[i] == 8'h00 || b[i] == crht_pkg::KEY_CUT_CHAR) begin
        cut = 1'b1;
      end
      if (cut) begin
        b[i] = 8'h00;
      end
    end
    return b;
  endfunction

  assign in_if.ready = !f_valid_r || push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        f_valid_r    <= 1'b1;
        f_data_r.key <= normalize_key(in_if.key_head, in_if.key_tail);
        f_data_r.now <= in_if.now_seconds;
      end else if (push_ready) begin
        f_valid_r <= 1'b0;
      end
    end
  end

  assign push_valid = f_valid_r;
  assign push_data  = f_data_r;

endmodule

// ----- rtl/crht_queue.sv -----
// ----------------------------------------------------------------------------
// Callsign holdoff table request queue
// Two-entry queue that lets the front end and the scan engine stall apart.
// ----------------------------------------------------------------------------
module crht_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  crht_pkg::req_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output crht_pkg::req_t pop_data
);

  crht_pkg::req_t slots_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        slots_r[wr_ptr_r] <= push_data;
        wr_ptr_r          <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/crht_back.sv -----
// ----------------------------------------------------------------------------
// Callsign holdoff table scan engine
// Scans the entry memory for a fresh match or a free entry and reports.
// ----------------------------------------------------------------------------
`include "callsign_repeat_holdoff_table_defines.svh"

module crht_back #(
  parameter int ENTRY_COUNT = crht_pkg::ENTRY_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  crht_pkg::req_t                 q_data,
  input  logic [crht_pkg::HOLDOFF_W-1:0] holdoff,
  crht_out_if.source                     out_if
);

  localparam int IDX_W  = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int SLOT_W = crht_pkg::SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t                   state_r;
  crht_pkg::req_t           req_r;
  logic [IDX_W-1:0]         rd_idx_r;
  logic                     issue_r;
  logic                     chk_vld_r;
  logic [IDX_W-1:0]         chk_idx_r;
  logic                     rd_live_r;
  crht_pkg::entry_t         rd_entry_r;
  logic                     hit_r;
  logic                     found_r;
  logic [IDX_W-1:0]         res_idx_r;
  logic [ENTRY_COUNT-1:0]   valid_r;
  logic                     out_valid_r;
  logic                     out_too_soon_r;
  logic                     out_recorded_r;
  logic [SLOT_W-1:0]        out_slot_r;
  crht_pkg::entry_t         mem_r [ENTRY_COUNT];

  logic [crht_pkg::STAMP_W-1:0] age;
  logic                         fresh;
  logic                         hit;
  logic                         out_free;
  logic                         done_load;
  logic                         do_write;

  // Age uses the modular 32-bit difference, so a wrapped clock still works.
  assign age       = req_r.now - rd_entry_r.stamp;
  assign fresh     = rd_live_r && (age < crht_pkg::STAMP_W'(holdoff));
  assign hit       = fresh && (rd_entry_r.key == req_r.key);
  assign out_free  = !out_valid_r || out_if.ready;
  assign done_load = (state_r == ST_DONE) && out_free;
  assign do_write  = done_load && !hit_r && found_r;
  assign q_ready   = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= 1'b0;
      chk_vld_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready && !done_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            req_r     <= q_data;
            rd_idx_r  <= '0;
            issue_r   <= 1'b1;
            chk_vld_r <= 1'b0;
            hit_r     <= 1'b0;
            found_r   <= 1'b0;
            res_idx_r <= '0;
            state_r   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Read of entry rd_idx_r overlaps the check of the entry read in the previous cycle.
          chk_vld_r <= issue_r;
          chk_idx_r <= rd_idx_r;
          rd_live_r <= valid_r[rd_idx_r];
          if (issue_r) begin
            if (rd_idx_r == LAST_IDX) begin
              issue_r <= 1'b0;
            end else begin
              rd_idx_r <= rd_idx_r + IDX_W'(1);
            end
          end
          if (chk_vld_r) begin
            if (hit) begin
              hit_r     <= 1'b1;
              res_idx_r <= chk_idx_r;
              state_r   <= ST_DONE;
            end else begin
              if (!fresh && !found_r) begin
                found_r   <= 1'b1;
                res_idx_r <= chk_idx_r;
              end
              if (chk_idx_r == LAST_IDX) begin
                state_r <= ST_DONE;
              end
            end
          end
        end
        ST_DONE: begin
          chk_vld_r <= 1'b0;
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_too_soon_r <= hit_r;
            out_recorded_r <= !hit_r && found_r;
            out_slot_r     <= SLOT_W'(res_idx_r);
            if (do_write) begin
              valid_r[res_idx_r] <= 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && issue_r) begin
      rd_entry_r <= mem_r[rd_idx_r];
    end
    if (do_write) begin
      mem_r[res_idx_r] <= '{key: req_r.key, stamp: req_r.now};
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.too_soon  = out_too_soon_r;
  assign out_if.recorded  = out_recorded_r;
  assign out_if.slot_used = out_slot_r;

  `CRHT_ASSERT_NOW(a_result_exclusive, out_valid_r, !(out_too_soon_r && out_recorded_r), "result is both refused and recorded")
  `CRHT_ASSERT_NOW(a_slot_zero_when_unused, out_valid_r && !out_too_soon_r && !out_recorded_r, out_slot_r == '0, "slot is nonzero with no match and no write")
  `CRHT_ASSERT_NEXT(a_write_sets_valid, do_write, valid_r[$past(res_idx_r)], "written entry did not become valid")
  `CRHT_ASSERT_NEXT(a_pop_starts_scan, state_r == ST_IDLE && q_valid, state_r == ST_SCAN && issue_r, "popped request did not start a scan")

endmodule

// ----- rtl/callsign_repeat_holdoff_table.sv -----
// The scan engine takes a new request only in its idle state, once the previous result is
// loaded; it reads the single-port entry memory one entry per cycle, and a fresh match ends
// the scan early.
// A two-entry queue keeps requests flowing in while a scan runs or a result waits.
// Reset (synchronous, rst_n low) clears all entry valid bits at once and sets the holdoff
// window to 30 seconds; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Callsign repeat holdoff table
// Refuses a callsign seen within the holdoff window and records new ones when an entry is free.
// ----------------------------------------------------------------------------
module callsign_repeat_holdoff_table #(
  parameter int ENTRY_COUNT = crht_pkg::ENTRY_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  crht_in_if.sink                         in_if,
  crht_out_if.source                      out_if,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [crht_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [crht_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [crht_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  logic                           push_valid;
  logic                           push_ready;
  crht_pkg::req_t                 push_data;
  logic                           pop_valid;
  logic                           pop_ready;
  crht_pkg::req_t                 pop_data;
  logic [crht_pkg::HOLDOFF_W-1:0] holdoff;

  crht_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .holdoff     (holdoff)
  );

  crht_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  crht_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  crht_back #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_data  (pop_data),
    .holdoff (holdoff),
    .out_if  (out_if)
  );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Callsign repeat holdoff table testbench
// Sends callsign requests with timestamps and changes the holdoff window
// between bursts. A scoreboard keeps its own copy of the entries, works out
// each verdict and checks every result in order. Both channels stall at
// random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ENTRIES          = crht_pkg::ENTRY_COUNT_DEF;
  localparam int KEY_BYTES        = crht_pkg::KEY_W / 8;
  localparam int GAP_MAX          = 12;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = ENTRIES + 8;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int POOL_SIZE        = 40;
  localparam int PHASES           = 12;
  localparam int PHASE_ITEMS      = 57;
  localparam int PRESSURE_PHASE   = 4;
  localparam int MAX_REPORTS      = 30;

  localparam logic [crht_pkg::CFG_ADDR_W-1:0] HOLDOFF_ADDR = {crht_pkg::REG_HOLDOFF, 2'b00};
  localparam logic [crht_pkg::CFG_ADDR_W-1:0] UNUSED_ADDR  = {~crht_pkg::REG_HOLDOFF, 2'b00};

  typedef struct packed {
    logic                        too_soon;
    logic                        recorded;
    logic [crht_pkg::SLOT_W-1:0] slot;
  } verdict_t;

  class holdoff_scoreboard;
    crht_pkg::key_t                 slot_key[ENTRIES];
    logic [crht_pkg::STAMP_W-1:0]   slot_stamp[ENTRIES];
    bit                             slot_valid[ENTRIES];
    logic [crht_pkg::HOLDOFF_W-1:0] holdoff;
    verdict_t                       verdict_q[$];
    int                             errors = 0;
    int                             requests = 0;
    int                             refused = 0;
    int                             stored = 0;
    int                             dropped = 0;

    function new();
      holdoff = crht_pkg::HOLDOFF_RESET;
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_stamp[i] = '0;
        slot_key[i]   = '0;
      end
    endfunction

    // Bytes from the first NUL or '>' onward count as zero.
    function crht_pkg::key_t normalize(crht_pkg::key_t raw);
      crht_pkg::key_t norm;
      bit             cut;
      norm = raw;
      cut  = 1'b0;
      for (int b = 0; b < KEY_BYTES; b++) begin
        if (norm[crht_pkg::KEY_W-1-8*b -: 8] == 8'h00 ||
            norm[crht_pkg::KEY_W-1-8*b -: 8] == crht_pkg::KEY_CUT_CHAR)
          cut = 1'b1;
        if (cut)
          norm[crht_pkg::KEY_W-1-8*b -: 8] = 8'h00;
      end
      return norm;
    endfunction

    function void note_request(crht_pkg::key_t raw, logic [crht_pkg::STAMP_W-1:0] now);
      crht_pkg::key_t               norm;
      logic [crht_pkg::STAMP_W-1:0] age;
      int                           free_slot;
      verdict_t                     v;
      norm      = normalize(raw);
      free_slot = -1;
      v         = '0;
      requests++;
      for (int i = 0; i < ENTRIES; i++) begin
        age = now - slot_stamp[i];
        if (slot_valid[i] && age < holdoff) begin
          if (slot_key[i] == norm) begin
            v.too_soon = 1'b1;
            v.slot     = i[crht_pkg::SLOT_W-1:0];
            break;
          end
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (v.too_soon) begin
        refused++;
      end else if (free_slot >= 0) begin
        slot_key[free_slot]   = norm;
        slot_stamp[free_slot] = now;
        slot_valid[free_slot] = 1'b1;
        v.recorded            = 1'b1;
        v.slot                = free_slot[crht_pkg::SLOT_W-1:0];
        stored++;
      end else begin
        dropped++;
      end
      verdict_q.push_back(v);
    endfunction

    function void report_mismatch(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no request outstanding, got %0d/%0d/%0d",
                   $time, got.too_soon, got.recorded, got.slot);
        return;
      end
      want = verdict_q.pop_front();
      if (got.too_soon !== want.too_soon)
        report_mismatch("too_soon", want.too_soon, got.too_soon);
      if (got.recorded !== want.recorded)
        report_mismatch("recorded", want.recorded, got.recorded);
      if (got.slot !== want.slot)
        report_mismatch("slot_used", want.slot, got.slot);
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [crht_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [crht_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [crht_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  crht_in_if  in_ch();
  crht_out_if out_ch();

  holdoff_scoreboard sb = new();

  bit quiet_in    = 1'b0;
  bit quiet_out   = 1'b0;
  bit long_hold   = 1'b0;
  int cycle_count = 0;
  int cfg_writes  = 0;

  crht_pkg::key_t pool_key[POOL_SIZE];
  int             pool_len[POOL_SIZE];

  callsign_repeat_holdoff_table #(
    .ENTRY_COUNT(ENTRIES)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request({in_ch.key_head, in_ch.key_tail}, in_ch.now_seconds);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.too_soon, out_ch.recorded, out_ch.slot_used});
  end

  // Result side: a random wait before each result, and one long hold on request.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = quiet_out ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_request(crht_pkg::key_t raw, logic [crht_pkg::STAMP_W-1:0] now);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.key_head    <= raw[crht_pkg::KEY_W-1 -: 64];
    in_ch.key_tail    <= raw[7:0];
    in_ch.now_seconds <= now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes a register, then reads the holdoff back and compares it.
  task automatic cfg_write(logic [crht_pkg::CFG_ADDR_W-1:0] addr,
                           logic [crht_pkg::CFG_DATA_W-1:0] data);
    logic [crht_pkg::CFG_DATA_W-1:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == HOLDOFF_ADDR)
      sb.holdoff = data[crht_pkg::HOLDOFF_W-1:0];
    cfg_writes++;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= HOLDOFF_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== crht_pkg::CFG_DATA_W'(sb.holdoff)) begin
      sb.errors++;
      $display("%0t: holdoff readback mismatch, expected %0d, got %0d",
               $time, sb.holdoff, got);
    end
  endtask

  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == crht_pkg::KEY_CUT_CHAR);
    return b;
  endfunction

  // Puts a random terminator and random trailing bytes after a short name.
  function automatic crht_pkg::key_t dress_key(crht_pkg::key_t norm, int len);
    crht_pkg::key_t raw;
    raw = norm;
    if (len < KEY_BYTES) begin
      raw[crht_pkg::KEY_W-1-8*len -: 8] = $urandom_range(0, 1) ? crht_pkg::KEY_CUT_CHAR
                                                              : 8'h00;
      for (int b = len + 1; b < KEY_BYTES; b++)
        raw[crht_pkg::KEY_W-1-8*b -: 8] = 8'($urandom());
    end
    return raw;
  endfunction

  initial begin
    crht_pkg::key_t                 raw;
    logic [crht_pkg::STAMP_W-1:0]   now_s;
    logic [crht_pkg::HOLDOFF_W-1:0] hold;
    int                             span;
    int                             idx;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.key_head    <= '0;
    in_ch.key_tail    <= '0;
    in_ch.now_seconds <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;

    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_len[k] = $urandom_range(1, KEY_BYTES);
      pool_key[k] = '0;
      for (int b = 0; b < pool_len[k]; b++)
        pool_key[k][crht_pkg::KEY_W-1-8*b -: 8] = name_byte();
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting with the reset holdoff of 30 seconds.
    send_request({crht_pkg::KEY_W{1'b1}}, 32'd1000);
    send_request({crht_pkg::KEY_W{1'b1}}, 32'd1000);
    send_request('0, 32'd1001);
    send_request({crht_pkg::KEY_CUT_CHAR, 32'($urandom()), 32'($urandom())}, 32'd1002);
    send_request({16'h4142, 8'h00, {48{1'b1}}}, 32'd1003);
    send_request({16'h4142, crht_pkg::KEY_CUT_CHAR, 48'h1234_5678_9ABC}, 32'd1004);
    send_request({64'h4142_4344_4546_4748, crht_pkg::KEY_CUT_CHAR}, 32'd1005);
    // One second inside the window, then exactly at its end.
    send_request({crht_pkg::KEY_W{1'b1}}, 32'd1029);
    send_request({crht_pkg::KEY_W{1'b1}}, 32'd1030);
    // The clock wraps between these two requests.
    send_request({16'h5731, crht_pkg::KEY_CUT_CHAR, 48'hFFFF_0000_FFFF}, 32'hFFFF_FFF0);
    send_request({16'h5731, 8'h00, 48'h0000_FFFF_0000}, 32'd5);
    wait_drained();
    cfg_write(HOLDOFF_ADDR, 32'hABCD_0000);
    send_request({16'h5731, 8'h00, 48'h0}, 32'd5);
    send_request({16'h5731, 8'h00, 48'h0}, 32'd5);
    wait_drained();
    cfg_write(HOLDOFF_ADDR, 32'h5A5A_003C);
    cfg_write(UNUSED_ADDR, 32'h0000_0007);
    send_request({8'h41, 64'h0}, 32'd2000);
    send_request({16'h4B39, 56'h0}, 32'd2000);
    // Time runs backward, leaving the same callsign in two entries.
    send_request({16'h4B39, 56'h0}, 32'd1900);
    send_request({16'h4B39, 56'h0}, 32'd2005);
    wait_drained();
    cfg_write(HOLDOFF_ADDR, 32'd200);
    send_request({16'h4B39, crht_pkg::KEY_CUT_CHAR, 48'h0}, 32'd2006);

    now_s = 32'd2100;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: hold = '1;
        1: hold = '0;
        2: hold = 16'd1;
        default: begin
          case ($urandom_range(0, 4))
            0: hold = crht_pkg::HOLDOFF_RESET;
            1: hold = '1;
            2, 3: hold = 16'($urandom_range(2, 60));
            default: hold = 16'($urandom_range(0, 65535));
          endcase
        end
      endcase
      cfg_write(HOLDOFF_ADDR, {16'($urandom()), hold});
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      span      = (p == 0) ? POOL_SIZE : $urandom_range(4, POOL_SIZE);
      if (p == PRESSURE_PHASE) begin
        quiet_in  = 1'b1;
        long_hold = 1'b1;
      end
      if (p >= 3) begin
        case ($urandom_range(0, 2))
          0: now_s = $urandom();
          1: now_s = '1 - $urandom_range(0, 40);
          default: ;
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 49))
          0: now_s = $urandom();
          1: now_s = now_s - $urandom_range(1, 100);
          2: now_s = now_s + hold + $urandom_range(0, 3);
          default: now_s = now_s + $urandom_range(0, 2);
        endcase
        if ($urandom_range(0, 6) == 0) begin
          raw = {32'($urandom()), 32'($urandom()), 8'($urandom())};
        end else begin
          idx = $urandom_range(0, span - 1);
          raw = dress_key(pool_key[idx], pool_len[idx]);
        end
        send_request(raw, now_s);
        if ($urandom_range(0, 39) == 0)
          wait_drained();
      end
    end

    wait_drained();
    $display("Covered %0d requests: %0d refused, %0d recorded, %0d with every entry fresh,",
             sb.requests, sb.refused, sb.stored, sb.dropped);
    $display("over %0d register writes, random stalls on both channels and one long hold.",
             cfg_writes);
    if (sb.errors == 0 && sb.verdict_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/crht_pkg.sv
rtl/crht_ifs.sv
rtl/crht_cfg.sv
rtl/crht_front.sv
rtl/crht_queue.sv
rtl/crht_back.sv
rtl/callsign_repeat_holdoff_table.sv
dv/testbench.sv
